// ----- rtl/assert_macros.svh -----
// Shared assertion macros for the lens remap block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition holds on every rising clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   `ASSERT_CLK(lbl, clk, rst, (1'b1) |-> (cond), msg)

`endif

// ----- rtl/luc_pkg.sv -----
package luc_pkg;

   localparam int FRAC      = 28;
   localparam int DIV_STEPS = 48;
   localparam int MATH_STAGES = 9;

   localparam logic signed [31:0] Q_ONE   = 32'sh1000_0000;
   localparam logic signed [31:0] Q_MAX   = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;

   typedef enum logic [2:0] {
      CSR_K1 = 3'd0,
      CSR_K2 = 3'd1,
      CSR_P1 = 3'd2,
      CSR_P2 = 3'd3,
      CSR_FX = 3'd4,
      CSR_FY = 3'd5,
      CSR_CX = 3'd6,
      CSR_CY = 3'd7
   } csr_index_type;

   // One lane of the restoring divider between steps.
   typedef struct packed {
      logic [20:0] rem;
      logic [47:0] dvd;
      logic [31:0] quo;
      logic        hi;
      logic        neg;
      logic        zero;
   } div_lane_type;

   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      logic signed [35:0] s;
      p = a * b;
      s = p[63:28];
      if (s > 36'sh0_7fff_ffff) begin
         return Q_MAX;
      end else if (s < -36'sh0_8000_0000) begin
         return Q_MIN;
      end
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         return s[32] ? Q_MIN : Q_MAX;
      end
      return s[31:0];
   endfunction

endpackage

// ----- rtl/luc_req_if.sv -----
interface luc_req_if;
   logic       valid;
   logic       ready;
   logic [9:0] out_col;
   logic [9:0] out_row;

   modport source (output valid, output out_col, output out_row, input ready);
   modport sink (input valid, input out_col, input out_row, output ready);
endinterface

// ----- rtl/luc_rsp_if.sv -----
interface luc_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] src_col;
   logic [9:0] src_row;
   logic       in_bounds;

   modport source (output valid, output src_col, output src_row, output in_bounds,
                   input ready);
   modport sink (input valid, input src_col, input src_row, input in_bounds,
                 output ready);
endinterface

// ----- rtl/luc_norm.sv -----
`include "assert_macros.svh"

module luc_norm
   import luc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [9:0]         in_col,
   input  logic [9:0]         in_row,
   input  logic [19:0]        focal_x,
   input  logic [19:0]        focal_y,
   input  logic [19:0]        center_x,
   input  logic [19:0]        center_y,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [31:0] out_x,
   output logic signed [31:0] out_y
);

   localparam int LAST = DIV_STEPS + 1;

   logic [LAST:0]      v_ff;
   logic [LAST:0]      v_in;
   logic [LAST:0]      en;
   div_lane_type       st_ff [0:DIV_STEPS][0:1];
   div_lane_type       st_in [0:DIV_STEPS][0:1];
   logic signed [31:0] res_ff [0:1];
   logic signed [31:0] res_in [0:1];
   logic [19:0]        focal [0:1];
   logic [19:0]        center [0:1];
   logic [9:0]         pix [0:1];

   assign focal[0]  = focal_x;
   assign focal[1]  = focal_y;
   assign center[0] = center_x;
   assign center[1] = center_y;
   assign pix[0]    = in_col;
   assign pix[1]    = in_row;

   // Stage advances when empty or when the next one advances.
   always_comb begin
      en[LAST] = !v_ff[LAST] || out_ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k + 1];
      end
      v_in[0] = en[0] ? in_valid : v_ff[0];
      for (int k = 1; k <= LAST; k++) begin
         v_in[k] = en[k] ? v_ff[k - 1] : v_ff[k];
      end
   end

   always_comb begin
      logic signed [21:0] num;
      logic signed [21:0] mag;
      logic [20:0]        r;
      logic               qb;
      div_lane_type       p;
      logic               sat;
      for (int l = 0; l < 2; l++) begin
         num = $signed({4'd0, pix[l], 8'd0}) - $signed({2'd0, center[l]});
         mag = num[21] ? -num : num;
         st_in[0][l].rem  = '0;
         st_in[0][l].dvd  = {mag[19:0], 28'd0};
         st_in[0][l].quo  = '0;
         st_in[0][l].hi   = 1'b0;
         st_in[0][l].neg  = num[21];
         st_in[0][l].zero = (num == '0);
      end
      // One quotient bit per step, most significant first.
      for (int k = 1; k <= DIV_STEPS; k++) begin
         for (int l = 0; l < 2; l++) begin
            p  = st_ff[k - 1][l];
            r  = {p.rem[19:0], p.dvd[47]};
            qb = (r >= {1'b0, focal[l]});
            st_in[k][l].rem  = qb ? (r - {1'b0, focal[l]}) : r;
            st_in[k][l].dvd  = {p.dvd[46:0], 1'b0};
            st_in[k][l].quo  = {p.quo[30:0], qb};
            st_in[k][l].hi   = p.hi | p.quo[31];
            st_in[k][l].neg  = p.neg;
            st_in[k][l].zero = p.zero;
         end
      end
      for (int l = 0; l < 2; l++) begin
         p   = st_ff[DIV_STEPS][l];
         sat = p.hi | p.quo[31];
         if (p.zero) begin
            res_in[l] = '0;
         end else if (sat) begin
            res_in[l] = p.neg ? Q_MIN : Q_MAX;
         end else begin
            res_in[l] = p.neg ? -$signed(p.quo) : $signed(p.quo);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
      for (int k = 0; k <= DIV_STEPS; k++) begin
         if (en[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
      if (en[LAST]) begin
         res_ff <= res_in;
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[LAST];
   assign out_x     = res_ff[0];
   assign out_y     = res_ff[1];

   `ASSERT_CLK(a_norm_hold, clock, reset, (v_ff[1] && !en[1]) |=> v_ff[1],
               "divider step lost a request while stalled")
   `ASSERT_CLK(a_norm_last, clock, reset, (v_ff[DIV_STEPS] && en[LAST]) |=> v_ff[LAST],
               "divider result stage missed a request")
   `ASSERT_ALWAYS(a_norm_empty, clock, reset, v_ff[0] || in_ready,
                  "divider refused a request while its first stage is empty")

endmodule

// ----- rtl/lens_undistort_source_coordinate.sv -----
// Maps each undistorted pixel (out_col, out_row) to the floored source pixel of the
// distorted image under the radial-tangential lens model, one request per clock
// unless rsp_chan.ready stalls the pipeline. The two parallel restoring dividers
// that normalize the coordinate have one setup stage, 48 quotient-bit steps, one
// sign/saturate stage; then the distortion polynomial and pixel mapping. Each stage
// holds on its own when full and stalled, so bubbles close up under back-pressure.
// Write the coefficient and intrinsic registers only while no request is in flight.
`include "assert_macros.svh"

module lens_undistort_source_coordinate
   import luc_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 1024,
   parameter int IMAGE_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   luc_req_if.sink     req_chan,
   luc_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int NS = MATH_STAGES;
   localparam logic [29:0] WIDTH_Q8  = 30'(IMAGE_WIDTH * 256);
   localparam logic [29:0] HEIGHT_Q8 = 30'(IMAGE_HEIGHT * 256);

   logic signed [31:0] k1_ff, k2_ff, p1_ff, p2_ff;
   logic [19:0]        fx_ff, fy_ff, cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff <= -32'sd76076785;
         k2_ff <= 32'sd19853237;
         p1_ff <= 32'sd51966;
         p2_ff <= 32'sd4730;
         fx_ff <= 20'd117415;
         fy_ff <= 20'd117068;
         cx_ff <= 20'd94007;
         cy_ff <= 20'd63584;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_K1: k1_ff <= csr_data;
            CSR_K2: k2_ff <= csr_data;
            CSR_P1: p1_ff <= csr_data;
            CSR_P2: p2_ff <= csr_data;
            CSR_FX: fx_ff <= csr_data[19:0];
            CSR_FY: fy_ff <= csr_data[19:0];
            CSR_CX: cx_ff <= csr_data[19:0];
            CSR_CY: cy_ff <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   logic               nv;
   logic signed [31:0] nx, ny;
   logic [NS:1]        v_ff, v_in, en;

   luc_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_col    (req_chan.out_col),
      .in_row    (req_chan.out_row),
      .focal_x   (fx_ff),
      .focal_y   (fy_ff),
      .center_x  (cx_ff),
      .center_y  (cy_ff),
      .out_valid (nv),
      .out_ready (en[1]),
      .out_x     (nx),
      .out_y     (ny)
   );

   always_comb begin
      en[NS] = !v_ff[NS] || rsp_chan.ready;
      for (int k = NS - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k + 1];
      end
      v_in[1] = en[1] ? nv : v_ff[1];
      for (int k = 2; k <= NS; k++) begin
         v_in[k] = en[k] ? v_ff[k - 1] : v_ff[k];
      end
   end

   // stage registers
   logic signed [31:0] x1_ff, y1_ff, x2_ff, y2_ff, xy_ff;
   logic signed [31:0] x_s2_ff, y_s2_ff, r2_ff, ax_ff, ay_ff, p1xy_ff, p2xy_ff;
   logic signed [31:0] x_s3_ff, y_s3_ff, r4_ff, k1r2_ff, tx_ff, ty_ff, tcx_ff, tcy_ff;
   logic signed [31:0] x_s4_ff, y_s4_ff, k2r4_ff, s1_ff, px_ff, py_ff;
   logic signed [31:0] tcx_s4_ff, tcy_s4_ff;
   logic signed [31:0] x_s5_ff, y_s5_ff, rad_ff, tcx_s5_ff, tcy_s5_ff, px_s5_ff, py_s5_ff;
   logic signed [31:0] xr_ff, yr_ff, tcx_s6_ff, tcy_s6_ff, px_s6_ff, py_s6_ff;
   logic signed [31:0] xd_ff, yd_ff;
   logic signed [52:0] mx_ff, my_ff;
   logic [9:0]         col_ff, row_ff;
   logic               inb_ff;

   logic signed [29:0] ud_in, vd_in;
   logic               inb_in;

   always_comb begin
      ud_in  = $signed({{5{mx_ff[52]}}, mx_ff[52:28]}) + $signed({10'd0, cx_ff});
      vd_in  = $signed({{5{my_ff[52]}}, my_ff[52:28]}) + $signed({10'd0, cy_ff});
      inb_in = !ud_in[29] && !vd_in[29] &&
               (ud_in < $signed(WIDTH_Q8)) && (vd_in < $signed(HEIGHT_Q8));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
      if (en[1]) begin
         x1_ff <= nx;
         y1_ff <= ny;
         x2_ff <= qmul(nx, nx);
         y2_ff <= qmul(ny, ny);
         xy_ff <= qmul(nx, ny);
      end
      if (en[2]) begin
         x_s2_ff <= x1_ff;
         y_s2_ff <= y1_ff;
         r2_ff   <= qadd(x2_ff, y2_ff);
         ax_ff   <= qadd(x2_ff, x2_ff);
         ay_ff   <= qadd(y2_ff, y2_ff);
         p1xy_ff <= qmul(p1_ff, xy_ff);
         p2xy_ff <= qmul(p2_ff, xy_ff);
      end
      if (en[3]) begin
         x_s3_ff <= x_s2_ff;
         y_s3_ff <= y_s2_ff;
         r4_ff   <= qmul(r2_ff, r2_ff);
         k1r2_ff <= qmul(k1_ff, r2_ff);
         tx_ff   <= qadd(r2_ff, ax_ff);
         ty_ff   <= qadd(r2_ff, ay_ff);
         tcx_ff  <= qadd(p1xy_ff, p1xy_ff);
         tcy_ff  <= qadd(p2xy_ff, p2xy_ff);
      end
      if (en[4]) begin
         x_s4_ff   <= x_s3_ff;
         y_s4_ff   <= y_s3_ff;
         k2r4_ff   <= qmul(k2_ff, r4_ff);
         s1_ff     <= qadd(Q_ONE, k1r2_ff);
         px_ff     <= qmul(p2_ff, tx_ff);
         py_ff     <= qmul(p1_ff, ty_ff);
         tcx_s4_ff <= tcx_ff;
         tcy_s4_ff <= tcy_ff;
      end
      if (en[5]) begin
         x_s5_ff   <= x_s4_ff;
         y_s5_ff   <= y_s4_ff;
         rad_ff    <= qadd(s1_ff, k2r4_ff);
         tcx_s5_ff <= tcx_s4_ff;
         tcy_s5_ff <= tcy_s4_ff;
         px_s5_ff  <= px_ff;
         py_s5_ff  <= py_ff;
      end
      if (en[6]) begin
         xr_ff     <= qmul(x_s5_ff, rad_ff);
         yr_ff     <= qmul(y_s5_ff, rad_ff);
         tcx_s6_ff <= tcx_s5_ff;
         tcy_s6_ff <= tcy_s5_ff;
         px_s6_ff  <= px_s5_ff;
         py_s6_ff  <= py_s5_ff;
      end
      if (en[7]) begin
         xd_ff <= qadd(qadd(xr_ff, tcx_s6_ff), px_s6_ff);
         yd_ff <= qadd(qadd(yr_ff, tcy_s6_ff), py_s6_ff);
      end
      if (en[8]) begin
         mx_ff <= $signed({1'b0, fx_ff}) * xd_ff;
         my_ff <= $signed({1'b0, fy_ff}) * yd_ff;
      end
      // Zero the coordinates when the source falls outside the image.
      if (en[9]) begin
         inb_ff <= inb_in;
         col_ff <= inb_in ? ud_in[17:8] : 10'd0;
         row_ff <= inb_in ? vd_in[17:8] : 10'd0;
      end
   end

   assign rsp_chan.valid     = v_ff[NS];
   assign rsp_chan.src_col   = col_ff;
   assign rsp_chan.src_row   = row_ff;
   assign rsp_chan.in_bounds = inb_ff;

   `ASSERT_CLK(a_hold_mid, clock, reset, (v_ff[5] && !en[5]) |=> v_ff[5],
               "mid pipeline stage dropped a stalled request")
   `ASSERT_CLK(a_to_out, clock, reset, (v_ff[8] && en[9]) |=> v_ff[9],
               "output stage missed a request")
   `ASSERT_ALWAYS(a_oob_zero, clock, reset,
                  !v_ff[NS] || inb_ff || (col_ff == 10'd0 && row_ff == 10'd0),
                  "out of bounds result carries nonzero coordinates")

endmodule
